>>> hdl/wu_line_cell_walker_top_macros.svh
// Assertion macros for the line cell walker.
// Used by wu_line_cell_walker_top.sv; each expects clk and rst_n in scope.
`ifndef WU_LINE_CELL_WALKER_TOP_MACROS_SVH
`define WU_LINE_CELL_WALKER_TOP_MACROS_SVH

// Consequent holds in the same cycle as the antecedent
`define WLCW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wu_line_cell_walker: check failed");

// Consequent holds in the cycle after the antecedent
`define WLCW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wu_line_cell_walker: check failed");

`endif

>>> hdl/wlcw_pkg.sv
// Shared types and fixed constants of the line cell walker.
// No dependencies; imported by wu_line_cell_walker_top.
`default_nettype none

package wlcw_pkg;

    localparam int IN_W       = 13;  // endpoint coordinate width
    localparam int CELL_W     = 6;   // cell coordinate width
    localparam int SLOPE_BITS = 12;  // slope fraction bits (Q1.12)
    localparam int MAX_OUT    = 64;  // cell limit per segment
    localparam int CNT_W      = 7;   // holds 0..MAX_OUT
    localparam int QUO_W      = 13;  // slope magnitude, up to 4096
    localparam int DIV_ITER   = 13;  // one quotient bit per iteration
    localparam int DIV_CNT_W  = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ORDER,
        ST_DIV,
        ST_STEP,
        ST_WALK_LO,
        ST_WALK_HI,
        ST_FLUSH
    } wlcw_state_t;

endpackage

`default_nettype wire

>>> hdl/wu_line_cell_walker_top.sv
// Xiaolin Wu line cell walker: sequencer, shared adder and cell emitter.
// Depends on wlcw_pkg and wu_line_cell_walker_top_macros.svh.
`default_nettype none

`include "wu_line_cell_walker_top_macros.svh"

// A request is taken when start is high and busy is low; busy then stays high
// until the segment is finished. After the request come the axis swap
// (ST_PREP), endpoint ordering (ST_ORDER), restoring division for the slope
// (ST_DIV) and the forming of the signed step (ST_STEP). The walk then
// visits each candidate cell in turn (one or two per major step, up to 33
// steps), and a flush state ends the request.
// The division trial, the step negation and the intercept advance share one
// adder. Each cell appears for exactly one cycle with strobe high; the
// receiver must take it then, as there is no back-pressure. One cell is held
// back so that the final one can carry last_cell; a segment with no cell on
// the grid gives no strobe at all.
module wu_line_cell_walker_top
    import wlcw_pkg::*;
#(
    parameter int FRAC_BITS  = 8,
    parameter int GRID_CELLS = 32
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [IN_W-1:0]   start_x,
    input  wire logic [IN_W-1:0]   start_y,
    input  wire logic [IN_W-1:0]   end_x,
    input  wire logic [IN_W-1:0]   end_y,
    output logic                   strobe,
    output logic [CELL_W-1:0]      cell_x,
    output logic [CELL_W-1:0]      cell_y,
    output logic                   last_cell
);

    localparam int FBITS  = FRAC_BITS + SLOPE_BITS;
    localparam int ACC_W  = (FRAC_BITS + 20 > 28) ? FRAC_BITS + 20 : 28;
    localparam int BASE_W = ACC_W - FBITS;
    localparam int M_W    = (15 - FRAC_BITS > 2) ? 15 - FRAC_BITS : 2;
    localparam int CMP_W  = M_W + CELL_W;
    localparam int HALF   = 1 << (FRAC_BITS - 1);

    // state and datapath registers
    wlcw_state_t              state_reg, state_next;
    logic [IN_W-1:0]          a1_reg, a1_next;
    logic [IN_W-1:0]          b1_reg, b1_next;
    logic [IN_W-1:0]          a2_reg, a2_next;
    logic [IN_W-1:0]          b2_reg, b2_next;
    logic                     steep_reg, steep_next;
    logic                     neg_reg, neg_next;
    logic                     zero_reg, zero_next;
    logic [ACC_W-1:0]         rem_reg, rem_next;
    logic [ACC_W-1:0]         dsh_reg, dsh_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic [ACC_W-1:0]         step_reg, step_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [M_W-1:0]           m_reg, m_next;
    logic [M_W-1:0]           m_end_reg, m_end_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [CELL_W-1:0]        pend_x_reg, pend_x_next;
    logic [CELL_W-1:0]        pend_y_reg, pend_y_next;
    logic                     strobe_reg, strobe_next;
    logic [CELL_W-1:0]        cell_x_reg, cell_x_next;
    logic [CELL_W-1:0]        cell_y_reg, cell_y_next;
    logic                     last_reg, last_next;

    // shared adder
    logic [ACC_W-1:0]         alu_a, alu_b, alu_sum;
    logic                     alu_cin;

    // setup and walk terms
    logic                     accept;
    logic [IN_W-1:0]          adx, ady;
    logic                     steep_now;
    logic                     order_swap;
    logic [IN_W-1:0]          lo_a, hi_a, lo_b, hi_b;
    logic [IN_W-1:0]          dmaj, dmin_mag;
    logic                     dmin_neg;
    logic [IN_W:0]            rnd_lo, rnd_hi;
    logic                     div_bit;
    logic [QUO_W-1:0]         slope_mag;
    logic [ACC_W-1:0]         slope_sh;
    logic signed [ACC_W-1:0]  acc_sh;
    logic [BASE_W-1:0]        base;
    logic                     is_hi;
    logic signed [BASE_W:0]   cand_min;
    logic                     m_on_grid;
    logic                     cand_ok;
    logic [CELL_W-1:0]        cand_x, cand_y;
    logic [CNT_W-1:0]         walk_count;
    logic                     frac_nz;
    logic                     go_hi;
    logic                     go_on;

    assign accept = start && (state_reg == ST_IDLE);

    // shared adder: division trial, step negation, intercept advance
    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = step_reg;
        alu_cin = 1'b0;
        case (state_reg)
            ST_DIV:
            begin
                alu_a   = rem_reg;
                alu_b   = ~dsh_reg;
                alu_cin = 1'b1;
            end
            ST_STEP:
            begin
                alu_a   = '0;
                alu_b   = neg_reg ? ~slope_sh : slope_sh;
                alu_cin = neg_reg;
            end
            default:
            begin
                alu_a   = acc_reg;
                alu_b   = step_reg;
                alu_cin = 1'b0;
            end
        endcase
    end

    assign alu_sum = alu_a + alu_b + ACC_W'(alu_cin);

    // axis swap and endpoint ordering terms
    always_comb
    begin
        adx        = (a2_reg >= a1_reg) ? a2_reg - a1_reg : a1_reg - a2_reg;
        ady        = (b2_reg >= b1_reg) ? b2_reg - b1_reg : b1_reg - b2_reg;
        steep_now  = ady > adx;
        order_swap = a1_reg > a2_reg;
        lo_a       = order_swap ? a2_reg : a1_reg;
        hi_a       = order_swap ? a1_reg : a2_reg;
        lo_b       = order_swap ? b2_reg : b1_reg;
        hi_b       = order_swap ? b1_reg : b2_reg;
        dmaj       = hi_a - lo_a;
        dmin_neg   = hi_b < lo_b;
        dmin_mag   = dmin_neg ? lo_b - hi_b : hi_b - lo_b;
        rnd_lo     = {1'b0, lo_a} + (IN_W + 1)'(HALF);
        rnd_hi     = {1'b0, hi_a} + (IN_W + 1)'(HALF);
    end

    // slope terms
    assign div_bit   = ~alu_sum[ACC_W-1];
    assign slope_mag = zero_reg ? QUO_W'(1 << SLOPE_BITS) : quo_reg;
    assign slope_sh  = ACC_W'(slope_mag) << FRAC_BITS;

    // candidate cell of the walk
    always_comb
    begin
        acc_sh     = $signed(acc_reg) >>> FBITS;
        base       = acc_sh[BASE_W-1:0];
        is_hi      = (state_reg == ST_WALK_HI);
        cand_min   = $signed({base[BASE_W-1], base} + {{BASE_W{1'b0}}, is_hi});
        m_on_grid  = {{CELL_W{1'b0}}, m_reg} <= CMP_W'(GRID_CELLS);
        cand_ok    = !cand_min[BASE_W] && m_on_grid
                     && (cand_min <= $signed((BASE_W + 1)'(GRID_CELLS)));
        cand_x     = steep_reg ? CELL_W'(cand_min) : CELL_W'(m_reg);
        cand_y     = steep_reg ? CELL_W'(m_reg) : CELL_W'(cand_min);
        walk_count = count_reg + CNT_W'(cand_ok);
        frac_nz    = acc_reg[FBITS-1:0] != '0;
        go_hi      = frac_nz && (walk_count < CNT_W'(MAX_OUT));
        go_on      = (m_reg < m_end_reg) && (walk_count < CNT_W'(MAX_OUT));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_ORDER;
            end
            ST_ORDER:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(DIV_ITER - 1))
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                state_next = (m_reg <= m_end_reg) ? ST_WALK_LO : ST_FLUSH;
            end
            ST_WALK_LO:
            begin
                if (go_hi)
                begin
                    state_next = ST_WALK_HI;
                end
                else
                begin
                    state_next = go_on ? ST_WALK_LO : ST_FLUSH;
                end
            end
            ST_WALK_HI:
            begin
                state_next = go_on ? ST_WALK_LO : ST_FLUSH;
            end
            ST_FLUSH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and result register
    always_comb
    begin
        a1_next         = a1_reg;
        b1_next         = b1_reg;
        a2_next         = a2_reg;
        b2_next         = b2_reg;
        steep_next      = steep_reg;
        neg_next        = neg_reg;
        zero_next       = zero_reg;
        rem_next        = rem_reg;
        dsh_next        = dsh_reg;
        quo_next        = quo_reg;
        div_cnt_next    = div_cnt_reg;
        step_next       = step_reg;
        acc_next        = acc_reg;
        m_next          = m_reg;
        m_end_next      = m_end_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        strobe_next     = 1'b0;
        cell_x_next     = cell_x_reg;
        cell_y_next     = cell_y_reg;
        last_next       = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    a1_next         = start_x;
                    b1_next         = start_y;
                    a2_next         = end_x;
                    b2_next         = end_y;
                    count_next      = '0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_PREP:
            begin
                // steep: walk along y
                steep_next = steep_now;
                if (steep_now)
                begin
                    a1_next = b1_reg;
                    b1_next = a1_reg;
                    a2_next = b2_reg;
                    b2_next = a2_reg;
                end
            end
            ST_ORDER:
            begin
                // numerator 2*|dmin|*4096 + dmaj, divisor 2*dmaj aligned to the top bit
                rem_next     = ACC_W'({dmin_mag, dmaj});
                dsh_next     = ACC_W'({dmaj, 13'b0});
                zero_next    = (dmaj == '0);
                neg_next     = dmin_neg;
                quo_next     = '0;
                div_cnt_next = '0;
                m_next       = M_W'(rnd_lo >> FRAC_BITS);
                m_end_next   = M_W'(rnd_hi >> FRAC_BITS);
                acc_next     = ACC_W'(lo_b) << SLOPE_BITS;
            end
            ST_DIV:
            begin
                if (div_bit)
                begin
                    rem_next = alu_sum;
                end
                quo_next     = {quo_reg[QUO_W-2:0], div_bit};
                dsh_next     = dsh_reg >> 1;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
            end
            ST_STEP:
            begin
                step_next = alu_sum;
            end
            ST_WALK_LO, ST_WALK_HI:
            begin
                // hold one cell back so the final one can be marked
                if (cand_ok)
                begin
                    if (pend_valid_reg)
                    begin
                        strobe_next = 1'b1;
                        cell_x_next = pend_x_reg;
                        cell_y_next = pend_y_reg;
                        last_next   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_x_next     = cand_x;
                    pend_y_next     = cand_y;
                end
                count_next = walk_count;
                if (is_hi || !go_hi)
                begin
                    acc_next = alu_sum;
                    m_next   = m_reg + M_W'(1);
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    strobe_next = 1'b1;
                    cell_x_next = pend_x_reg;
                    cell_y_next = pend_y_reg;
                    last_next   = 1'b1;
                end
                pend_valid_next = 1'b0;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
            div_cnt_reg    <= div_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a1_reg     <= a1_next;
        b1_reg     <= b1_next;
        a2_reg     <= a2_next;
        b2_reg     <= b2_next;
        steep_reg  <= steep_next;
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        acc_reg    <= acc_next;
        m_reg      <= m_next;
        m_end_reg  <= m_end_next;
        pend_x_reg <= pend_x_next;
        pend_y_reg <= pend_y_next;
        cell_x_reg <= cell_x_next;
        cell_y_reg <= cell_y_next;
        last_reg   <= last_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign cell_x    = cell_x_reg;
    assign cell_y    = cell_y_reg;
    assign last_cell = last_reg;

    // checks
    `WLCW_ASSERT_NOW(a_last_after_flush, strobe && last_cell, state_reg == ST_IDLE)
    `WLCW_ASSERT_NEXT(a_no_cell_after_req, start && !busy, !strobe)
    `WLCW_ASSERT_NOW(a_count_limit, 1'b1, count_reg <= CNT_W'(MAX_OUT))
    `WLCW_ASSERT_NOW(a_cell_on_grid, strobe,
        (cell_x <= CELL_W'(GRID_CELLS)) && (cell_y <= CELL_W'(GRID_CELLS)))

endmodule

`default_nettype wire
